// ===== hdl/gwch_pkg.sv =====
// shared types for the gift wrap convex hull block
package gwch_pkg;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               final_point;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    logic [4:0]         src_index;
    logic               overflowed;
    logic               ring_end;
  } out_item_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef struct packed {
    acc_op_e acc_op;
  } mac_ctl_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } mac_sts_t;

endpackage

// ===== hdl/gift_wrap_convex_hull.sv =====
// gift wrap convex hull: point store, sequencer and output register
// load: one point per cycle, in_stall_o low while idle
// hull: one scan of all points finds the start, then one scan of all points per hull vertex
//   (one ram read and eight sequencer steps on the shared multiplier per candidate)
// the block is stalled on input from the final point until the closing vertex is registered
// reset clears state, point count, drop flag, scan indices, step and output valid; the point ram is not cleared
module gift_wrap_convex_hull #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gwch_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gwch_pkg::out_item_t out_data_o
);

  localparam int CW   = COORD_BITS;
  localparam int W    = CW + 1;
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int EW   = (CW > 16) ? CW : 16;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIND_RD = 4'd1;
  localparam logic [3:0] S_FIND_LD = 4'd2;
  localparam logic [3:0] S_EMIT    = 4'd3;
  localparam logic [3:0] S_SCAN_RD = 4'd4;
  localparam logic [3:0] S_SCAN_LD = 4'd5;
  localparam logic [3:0] S_MUL     = 4'd6;
  localparam logic [3:0] S_NEXT    = 4'd7;
  localparam logic [3:0] S_CLOSE   = 4'd8;

  localparam logic [2:0] MS_CROSS_A = 3'd0;
  localparam logic [2:0] MS_CROSS_B = 3'd1;
  localparam logic [2:0] MS_DOTBC_A = 3'd2;
  localparam logic [2:0] MS_DOTBC_B = 3'd3;
  localparam logic [2:0] MS_DOTDC_A = 3'd4;
  localparam logic [2:0] MS_DOTDC_B = 3'd5;
  localparam logic [2:0] MS_SUM     = 3'd6;
  localparam logic [2:0] MS_DECIDE  = 3'd7;

  function automatic logic signed [15:0] to16(input logic signed [CW-1:0] c);
    logic signed [EW-1:0] e;
    e = EW'(c);
    return e[15:0];
  endfunction

  function automatic logic [4:0] idx5(input logic [IW-1:0] i);
    logic [IW+4:0] t;
    t = (IW+5)'(i);
    return t[4:0];
  endfunction

  function automatic logic [W-1:0] absw(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  // control
  logic [3:0]      state_q, state_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            drop_q, drop_d;
  logic [IW-1:0]   j_q, j_d;
  logic [CNTW-1:0] emitted_q, emitted_d;
  logic            has_best_q, has_best_d;
  logic [2:0]      step_q, step_d;
  logic            out_valid_q, out_valid_d;

  // payload
  gwch_pkg::out_item_t  out_q, out_d;
  logic signed [CW-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic [IW-1:0]        start_idx_q, start_idx_d;
  logic signed [CW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [IW-1:0]        cur_idx_q, cur_idx_d;
  logic signed [CW-1:0] best_x_q, best_x_d, best_y_q, best_y_d;
  logic [IW-1:0]        best_idx_q, best_idx_d;
  logic signed [W-1:0]  bvx_q, bvx_d, bvy_q, bvy_d;
  logic signed [CW-1:0] cand_x_q, cand_x_d, cand_y_q, cand_y_d;
  logic [IW-1:0]        cand_idx_q, cand_idx_d;
  logic signed [W-1:0]  cvx_q, cvx_d, cvy_q, cvy_d;
  logic signed [W-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic                 cross_neg_q, cross_neg_d, cross_zero_q, cross_zero_d;
  logic                 dbc_neg_q, dbc_neg_d, dbc_zero_q, dbc_zero_d;

  // ram
  logic              ram_we;
  logic [IW-1:0]     ram_raddr;
  logic [2*CW-1:0]   ram_wdata;
  logic [2*CW-1:0]   ram_rdata;
  logic [EW-1:0]     raw_x, raw_y;
  logic signed [CW-1:0] in_x, in_y, rd_x, rd_y;
  logic signed [W-1:0]  rd_vx, rd_vy;

  // mac
  gwch_pkg::mac_ctl_t  mac_ctl;
  gwch_pkg::mac_sts_t  mac_sts;
  logic signed [W-1:0] op_a, op_b;

  logic            out_free;
  logic            last_j;
  logic            farther;
  logic            better;
  logic [W:0]      len_c, len_b;

  assign raw_x     = EW'($unsigned(in_data_i.px));
  assign raw_y     = EW'($unsigned(in_data_i.py));
  assign in_x      = raw_x[CW-1:0];
  assign in_y      = raw_y[CW-1:0];
  assign ram_wdata = {in_y, in_x};
  assign rd_x      = ram_rdata[CW-1:0];
  assign rd_y      = ram_rdata[2*CW-1:CW];
  assign rd_vx     = W'(rd_x) - W'(cur_x_q);
  assign rd_vy     = W'(rd_y) - W'(cur_y_q);

  gwch_ram #(
    .WIDTH (2*CW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gwch_mac #(
    .W (W)
  ) u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (op_a),
    .b_i   (op_b),
    .sts_o (mac_sts)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign last_j   = ((CNTW'(j_q) + CNTW'(1)) == count_q);
  assign len_c    = (W+1)'(absw(cvx_q)) + (W+1)'(absw(cvy_q));
  assign len_b    = (W+1)'(absw(bvx_q)) + (W+1)'(absw(bvy_q));
  assign farther  = (len_c > len_b);

  // candidate wins on a smaller angle; collinear same way goes to the farther point,
  // collinear opposite way goes to the one along the reference direction,
  // and to the farther one when both are square to it
  assign better = cross_neg_q ||
                  (cross_zero_q && ((!dbc_neg_q && !dbc_zero_q && farther) ||
                                    (dbc_neg_q && !mac_sts.neg &&
                                     (!mac_sts.zero || farther))));

  always_comb begin
    op_a = '0;
    op_b = '0;
    mac_ctl.acc_op = gwch_pkg::ACC_HOLD;
    case (step_q)
      MS_CROSS_A: begin op_a = bvx_q; op_b = cvy_q; end
      MS_CROSS_B: begin
        op_a = bvy_q; op_b = cvx_q;
        mac_ctl.acc_op = gwch_pkg::ACC_LOAD;
      end
      MS_DOTBC_A: begin
        op_a = bvx_q; op_b = cvx_q;
        mac_ctl.acc_op = gwch_pkg::ACC_SUB;
      end
      MS_DOTBC_B: begin
        op_a = bvy_q; op_b = cvy_q;
        mac_ctl.acc_op = gwch_pkg::ACC_LOAD;
      end
      MS_DOTDC_A: begin
        op_a = dx_q; op_b = cvx_q;
        mac_ctl.acc_op = gwch_pkg::ACC_ADD;
      end
      MS_DOTDC_B: begin
        op_a = dy_q; op_b = cvy_q;
        mac_ctl.acc_op = gwch_pkg::ACC_LOAD;
      end
      MS_SUM: mac_ctl.acc_op = gwch_pkg::ACC_ADD;
      default: mac_ctl.acc_op = gwch_pkg::ACC_HOLD;
    endcase
    if (state_q != S_MUL) begin
      mac_ctl.acc_op = gwch_pkg::ACC_HOLD;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    drop_d       = drop_q;
    j_d          = j_q;
    emitted_d    = emitted_q;
    has_best_d   = has_best_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    start_x_d    = start_x_q;
    start_y_d    = start_y_q;
    start_idx_d  = start_idx_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    cur_idx_d    = cur_idx_q;
    best_x_d     = best_x_q;
    best_y_d     = best_y_q;
    best_idx_d   = best_idx_q;
    bvx_d        = bvx_q;
    bvy_d        = bvy_q;
    cand_x_d     = cand_x_q;
    cand_y_d     = cand_y_q;
    cand_idx_d   = cand_idx_q;
    cvx_d        = cvx_q;
    cvy_d        = cvy_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    cross_neg_d  = cross_neg_q;
    cross_zero_d = cross_zero_q;
    dbc_neg_d    = dbc_neg_q;
    dbc_zero_d   = dbc_zero_q;
    ram_we       = 1'b0;
    ram_raddr    = j_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (count_q < CNTW'(MAX_POINTS)) begin
            ram_we  = 1'b1;
            count_d = count_q + CNTW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_data_i.final_point) begin
            j_d     = '0;
            state_d = S_FIND_RD;
          end
        end
      end
      S_FIND_RD: state_d = S_FIND_LD;
      S_FIND_LD: begin
        if (j_q == '0 || rd_x < start_x_q || (rd_x == start_x_q && rd_y < start_y_q)) begin
          start_x_d   = rd_x;
          start_y_d   = rd_y;
          start_idx_d = j_q;
        end
        if (last_j) begin
          cur_x_d   = start_x_d;
          cur_y_d   = start_y_d;
          cur_idx_d = start_idx_d;
          emitted_d = '0;
          dx_d      = '0;
          dy_d      = -W'(1);
          state_d   = S_EMIT;
        end else begin
          j_d     = j_q + IW'(1);
          state_d = S_FIND_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.hx         = to16(cur_x_q);
          out_d.hy         = to16(cur_y_q);
          out_d.src_index  = idx5(cur_idx_q);
          out_d.overflowed = drop_q;
          out_d.ring_end   = 1'b0;
          emitted_d        = emitted_q + CNTW'(1);
          if (emitted_q >= CNTW'(MAX_POINTS - 1)) begin
            state_d = S_CLOSE;
          end else begin
            j_d        = '0;
            has_best_d = 1'b0;
            state_d    = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: state_d = S_SCAN_LD;
      S_SCAN_LD: begin
        cand_x_d   = rd_x;
        cand_y_d   = rd_y;
        cand_idx_d = j_q;
        cvx_d      = rd_vx;
        cvy_d      = rd_vy;
        if (rd_vx != '0 || rd_vy != '0) begin
          if (!has_best_q) begin
            has_best_d = 1'b1;
            best_x_d   = rd_x;
            best_y_d   = rd_y;
            best_idx_d = j_q;
            bvx_d      = rd_vx;
            bvy_d      = rd_vy;
          end else begin
            step_d  = MS_CROSS_A;
            state_d = S_MUL;
          end
        end
        if (state_d != S_MUL) begin
          if (last_j) begin
            state_d = S_NEXT;
          end else begin
            j_d     = j_q + IW'(1);
            state_d = S_SCAN_RD;
          end
        end
      end
      S_MUL: begin
        step_d = step_q + 3'd1;
        if (step_q == MS_DOTBC_B) begin
          cross_neg_d  = mac_sts.neg;
          cross_zero_d = mac_sts.zero;
        end
        // dot of best and candidate sits in the accumulator for this one step
        if (step_q == MS_DOTDC_B) begin
          dbc_neg_d  = mac_sts.neg;
          dbc_zero_d = mac_sts.zero;
        end
        if (step_q == MS_DECIDE) begin
          if (better) begin
            best_x_d   = cand_x_q;
            best_y_d   = cand_y_q;
            best_idx_d = cand_idx_q;
            bvx_d      = cvx_q;
            bvy_d      = cvy_q;
          end
          if (last_j) begin
            state_d = S_NEXT;
          end else begin
            j_d     = j_q + IW'(1);
            state_d = S_SCAN_RD;
          end
        end
      end
      S_NEXT: begin
        if (!has_best_q || (best_x_q == start_x_q && best_y_q == start_y_q)) begin
          state_d = S_CLOSE;
        end else begin
          dx_d      = bvx_q;
          dy_d      = bvy_q;
          cur_x_d   = best_x_q;
          cur_y_d   = best_y_q;
          cur_idx_d = best_idx_q;
          state_d   = S_EMIT;
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.hx         = to16(start_x_q);
          out_d.hy         = to16(start_y_q);
          out_d.src_index  = idx5(start_idx_q);
          out_d.overflowed = drop_q;
          out_d.ring_end   = 1'b1;
          count_d          = '0;
          drop_d           = 1'b0;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      drop_q      <= 1'b0;
      j_q         <= '0;
      emitted_q   <= '0;
      has_best_q  <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      j_q         <= j_d;
      emitted_q   <= emitted_d;
      has_best_q  <= has_best_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q        <= out_d;
    start_x_q    <= start_x_d;
    start_y_q    <= start_y_d;
    start_idx_q  <= start_idx_d;
    cur_x_q      <= cur_x_d;
    cur_y_q      <= cur_y_d;
    cur_idx_q    <= cur_idx_d;
    best_x_q     <= best_x_d;
    best_y_q     <= best_y_d;
    best_idx_q   <= best_idx_d;
    bvx_q        <= bvx_d;
    bvy_q        <= bvy_d;
    cand_x_q     <= cand_x_d;
    cand_y_q     <= cand_y_d;
    cand_idx_q   <= cand_idx_d;
    cvx_q        <= cvx_d;
    cvy_q        <= cvy_d;
    dx_q         <= dx_d;
    dy_q         <= dy_d;
    cross_neg_q  <= cross_neg_d;
    cross_zero_q <= cross_zero_d;
    dbc_neg_q    <= dbc_neg_d;
    dbc_zero_q   <= dbc_zero_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= CNTW'(MAX_POINTS))
    else $error("too many hull vertices emitted");

  a_mul_has_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> has_best_q)
    else $error("angle compare without a current best");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLOSE && out_free) |=>
      (count_q == '0 && !drop_q && out_valid_o && out_data_o.ring_end))
    else $error("closing transfer did not clear the set");

endmodule

// ===== hdl/gwch_ram.sv =====
// generic single write port ram with registered read
module gwch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/gwch_mac.sv =====
// shared multiply accumulate unit with registered product
module gwch_mac #(
  parameter int W = 17
) (
  input  logic                clk_i,
  input  gwch_pkg::mac_ctl_t  ctl_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output gwch_pkg::mac_sts_t  sts_o
);

  logic signed [2*W-1:0] prod_q;
  logic signed [2*W:0]   acc_q;
  logic signed [2*W:0]   acc_d;
  logic signed [2*W:0]   prod_ext;

  assign prod_ext = (2*W+1)'(prod_q);

  always_comb begin
    acc_d = acc_q;
    unique case (ctl_i.acc_op)
      gwch_pkg::ACC_HOLD: acc_d = acc_q;
      gwch_pkg::ACC_LOAD: acc_d = prod_ext;
      gwch_pkg::ACC_ADD:  acc_d = acc_q + prod_ext;
      gwch_pkg::ACC_SUB:  acc_d = acc_q - prod_ext;
      default:            acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    acc_q  <= acc_d;
  end

  assign sts_o.neg  = acc_q[2*W];
  assign sts_o.zero = (acc_q == '0);

endmodule

// ===== bench/gift_wrap_convex_hull_test.sv =====
// testbench for the gift wrap convex hull block: directed table, then random point sets
module gift_wrap_convex_hull_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 32;
  localparam int LIMIT = 3000000;

  typedef enum int {PH_FREE, PH_SEND, PH_RECV, PH_BOTH} idle_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gwch_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gwch_pkg::out_item_t out_data;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gift_wrap_convex_hull DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  // predictor state
  logic signed [15:0] pts_x[CAP];
  logic signed [15:0] pts_y[CAP];
  int unsigned stored;
  bit dropped;
  gwch_pkg::out_item_t hull_q[$];

  int errors = 0;
  int cycles = 0;
  idle_e phase = PH_FREE;
  bit hold_recv = 1'b0;

  // table: point, final flag, typed result for the trivial rows (single point sets)
  typedef struct {
    gwch_pkg::in_item_t pt;
    bit has_exp;
    gwch_pkg::out_item_t e0;
  } row_t;

  function automatic gwch_pkg::out_item_t vertex(int idx, bit ring);
    gwch_pkg::out_item_t o;
    o.hx = pts_x[idx];
    o.hy = pts_y[idx];
    o.src_index = idx[4:0];
    o.overflowed = dropped;
    o.ring_end = ring;
    return o;
  endfunction

  task automatic check_item(string tag, gwch_pkg::out_item_t e, gwch_pkg::out_item_t a);
    if (a.hx !== e.hx) begin
      $error("%s hx expected %0d got %0d", tag, e.hx, a.hx); errors++;
    end
    if (a.hy !== e.hy) begin
      $error("%s hy expected %0d got %0d", tag, e.hy, a.hy); errors++;
    end
    if (a.src_index !== e.src_index) begin
      $error("%s src_index expected %0d got %0d", tag, e.src_index, a.src_index);
      errors++;
    end
    if (a.overflowed !== e.overflowed) begin
      $error("%s overflowed expected %0b got %0b", tag, e.overflowed, a.overflowed);
      errors++;
    end
    if (a.ring_end !== e.ring_end) begin
      $error("%s ring_end expected %0b got %0b", tag, e.ring_end, a.ring_end);
      errors++;
    end
  endtask

  // positive if candidate c has the smaller angle to the reference than b, zero on a tie, else negative
  function automatic int cos_order(longint dc, longint lc, longint db, longint lb);
    int sc, sb;
    logic [127:0] l, r;
    longint ac, ab;
    sc = (dc > 0) - (dc < 0);
    sb = (db > 0) - (db < 0);
    if (sc != sb) return sc - sb;
    if (sc == 0) return 0;
    ac = dc < 0 ? -dc : dc;
    ab = db < 0 ? -db : db;
    l = 128'(ac) * 128'(ac) * 128'(lb);
    r = 128'(ab) * 128'(ab) * 128'(lc);
    if (l == r) return 0;
    return ((l > r) ? 1 : -1) * sc;
  endfunction

  task automatic wrap_hull();
    int start, cur, best, count;
    longint dx, dy, bdot, blen, vx, vy, dt, ln, cx, cy;
    int c;
    start = 0;
    dx = 0;
    dy = -1;
    count = 0;
    if (stored == 0) return;
    for (int i = 1; i < stored; i++)
      if (pts_x[i] < pts_x[start] || (pts_x[i] == pts_x[start] && pts_y[i] < pts_y[start]))
        start = i;
    cur = start;
    forever begin
      hull_q.insert(hull_q.size(), vertex(cur, 1'b0));
      count++;
      if (count >= CAP) break;
      cx = pts_x[cur];
      cy = pts_y[cur];
      best = -1;
      bdot = 0;
      blen = 0;
      for (int j = 0; j < stored; j++) begin
        vx = longint'(pts_x[j]) - cx;
        vy = longint'(pts_y[j]) - cy;
        if (vx == 0 && vy == 0) continue;
        dt = dx * vx + dy * vy;
        ln = vx * vx + vy * vy;
        if (best < 0) begin
          best = j; bdot = dt; blen = ln;
        end else begin
          c = cos_order(dt, ln, bdot, blen);
          if (c > 0 || (c == 0 && ln > blen)) begin
            best = j; bdot = dt; blen = ln;
          end
        end
      end
      if (best < 0) break;
      if (pts_x[best] == pts_x[start] && pts_y[best] == pts_y[start]) break;
      dx = longint'(pts_x[best]) - cx;
      dy = longint'(pts_y[best]) - cy;
      cur = best;
    end
    hull_q.insert(hull_q.size(), vertex(start, 1'b1));
  endtask

  task automatic predict_point(gwch_pkg::in_item_t it);
    if (stored < CAP) begin
      pts_x[stored] = it.px;
      pts_y[stored] = it.py;
      stored++;
    end else begin
      dropped = 1'b1;
    end
    if (it.final_point) begin
      wrap_hull();
      stored = 0;
      dropped = 1'b0;
    end
  endtask

  function automatic bit idle_roll(bit sender);
    case (phase)
      PH_SEND: return sender && $urandom_range(99) < 54;
      PH_RECV: return !sender && $urandom_range(99) < 54;
      PH_BOTH: return $urandom_range(99) < 38;
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_point(gwch_pkg::in_item_t it);
    while (idle_roll(1'b1)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_point(it);
  endtask

  task automatic quiet();
    in_valid <= 1'b0;
    while (hull_q.size() != 0) @(posedge clk);
  endtask

  function automatic gwch_pkg::in_item_t mk(int x, int y, bit f);
    gwch_pkg::in_item_t it;
    it.px = x[15:0];
    it.py = y[15:0];
    it.final_point = f;
    return it;
  endfunction

  function automatic gwch_pkg::in_item_t rand_point(int spread, bit f);
    if (spread == 0)
      return mk($urandom_range(65535), $urandom_range(65535), f);
    return mk(int'($urandom_range(2 * spread)) - spread,
      int'($urandom_range(2 * spread)) - spread, f);
  endfunction

  task automatic send_set(int n, int spread);
    for (int i = 0; i < n; i++) send_point(rand_point(spread, i == n - 1));
  endtask

  // receiver: random stalls, check against oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (hull_q.size() == 0) begin
          $error("unexpected hull vertex %p", out_data);
          errors++;
        end else begin
          gwch_pkg::out_item_t e;
          e = hull_q.pop_front();
          check_item("output", e, out_data);
        end
      end
      out_stall <= hold_recv || idle_roll(1'b0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("gift_wrap_convex_hull_test NOT OK");
      $finish;
    end
  end

  // long receiver hold-off, counted here
  task automatic hold_off(int n);
    hold_recv = 1'b1;
    repeat (n) @(posedge clk);
    hold_recv = 1'b0;
  endtask

  row_t rows[$];
  gwch_pkg::out_item_t one;

  task automatic add_row(gwch_pkg::in_item_t pt, bit has_exp, gwch_pkg::out_item_t e0);
    row_t r;
    r.pt = pt;
    r.has_exp = has_exp;
    r.e0 = e0;
    rows.insert(rows.size(), r);
  endtask

  initial begin
    stored = 0;
    dropped = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single point sets at the extremes: emitted then repeated with ring_end
    one = '{hx: 16'sh8000, hy: 16'sh7fff, src_index: 0, overflowed: 0, ring_end: 0};
    add_row(mk(-32768, 32767, 1), 1'b1, one);
    one = '{hx: 16'sh7fff, hy: 16'sh8000, src_index: 0, overflowed: 0, ring_end: 0};
    add_row(mk(32767, -32768, 1), 1'b1, one);
    // square with duplicates and a collinear edge point
    add_row(mk(0, 0, 0), 1'b0, '0);
    add_row(mk(0, 0, 0), 1'b0, '0);
    add_row(mk(10, 0, 0), 1'b0, '0);
    add_row(mk(5, 0, 0), 1'b0, '0);
    add_row(mk(10, 10, 0), 1'b0, '0);
    add_row(mk(5, 5, 0), 1'b0, '0);
    add_row(mk(0, 10, 1), 1'b0, '0);
    // collinear pair and full-range corners
    add_row(mk(3, 3, 0), 1'b0, '0);
    add_row(mk(3, 3, 0), 1'b0, '0);
    add_row(mk(-7, 3, 1), 1'b0, '0);
    add_row(mk(-32768, -32768, 0), 1'b0, '0);
    add_row(mk(32767, -32768, 0), 1'b0, '0);
    add_row(mk(32767, 32767, 0), 1'b0, '0);
    add_row(mk(-32768, 32767, 0), 1'b0, '0);
    add_row(mk(0, 0, 1), 1'b0, '0);

    foreach (rows[i]) begin
      send_point(rows[i].pt);
      if (rows[i].has_exp) begin
        // typed check on the two entries this row just added
        one = rows[i].e0;
        check_item("table vertex", one, hull_q[hull_q.size() - 2]);
        one.ring_end = 1'b1;
        check_item("table ring", one, hull_q[hull_q.size() - 1]);
      end
    end

    // overflow: 35 points, the last three (final one included) dropped
    send_set(35, 1000);
    quiet();

    // receiver holds off while sender keeps offering
    fork
      hold_off(2000);
      send_set(20, 50);
    join
    quiet();

    for (int ph = 0; ph < 4; ph++) begin
      phase = idle_e'(ph);
      for (int s = 0; s < 3; s++) begin
        case ($urandom_range(3))
          0: send_set($urandom_range(1, 4), 3);
          1: send_set($urandom_range(3, 10), 100);
          2: send_set($urandom_range(4, 12), 0);
          default: send_set($urandom_range(2, 8), 20000);
        endcase
      end
      phase = PH_FREE;
      quiet();
    end

    quiet();
    repeat (200) @(posedge clk);
    if (errors == 0 && hull_q.size() == 0)
      $display("gift_wrap_convex_hull_test OK");
    else
      $display("gift_wrap_convex_hull_test NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gwch_pkg.sv
hdl/gwch_ram.sv
hdl/gwch_mac.sv
hdl/gift_wrap_convex_hull.sv
bench/gift_wrap_convex_hull_test.sv
